[rtl/mfp_pkg.sv]
// types, constants and interface structs shared by the frame parser modules
`timescale 1ns / 1ps

package mfp_pkg;

  // field widths
  localparam int PORT_W      = 2;
  localparam int BYTE_W      = 8;
  localparam int SIZE_W      = 7;
  localparam int INDEX_W     = 6;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // defaults for the top-level parameters
  localparam int DEF_PORTS       = 4;
  localparam int DEF_MAX_PAYLOAD = 64;

  // depth of the frame queue between front and back
  localparam int Q_DEPTH = 2;

  // header bytes
  localparam logic [BYTE_W-1:0] HDR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] HDR_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] HDR_ARROW  = 8'h3C;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DOLLAR,
    PH_M,
    PH_ARROW,
    PH_CMD,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_OUT
  } back_state_t;

  // one checked frame waiting to be sent out
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [BYTE_W-1:0] command;
    logic [SIZE_W-1:0] size;
  } frame_desc_t;

  // payload store write from the front
  typedef struct packed {
    logic               en;
    logic [PORT_W-1:0]  port;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  data;
  } mem_wr_t;

  // back has sent the last result of a port's frame
  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
  } frame_done_t;

endpackage

[rtl/mfp_front.sv]
// per-port header hunt, size and checksum tracking, payload capture
`timescale 1ns / 1ps

module mfp_front #(
  parameter int PORTS       = mfp_pkg::DEF_PORTS,
  parameter int MAX_PAYLOAD = mfp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mfp_pkg::PORT_W-1:0]  in_port,
  input  logic [mfp_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        q_full,
  output logic                        push,
  output mfp_pkg::frame_desc_t        push_desc,
  output mfp_pkg::mem_wr_t            wr,
  input  mfp_pkg::frame_done_t        done
);

  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;

  mfp_pkg::phase_t              phase_r [PORTS];
  logic [mfp_pkg::SIZE_W-1:0]   size_r  [PORTS];
  logic [mfp_pkg::SIZE_W-1:0]   taken_r [PORTS];
  logic [mfp_pkg::BYTE_W-1:0]   xor_r   [PORTS];
  logic [mfp_pkg::BYTE_W-1:0]   cmd_r   [PORTS];
  logic [PORTS-1:0]             busy_r;
  logic [PORTS-1:0]             busy_nxt;

  logic [PIW-1:0]               sel;
  logic                         port_ok;
  logic                         accept;
  logic                         has_room;
  logic                         size_ok;
  mfp_pkg::phase_t              cur_phase;
  mfp_pkg::phase_t              phase_nxt;
  logic [mfp_pkg::SIZE_W-1:0]   cur_size;
  logic [mfp_pkg::SIZE_W-1:0]   cur_taken;
  logic [mfp_pkg::BYTE_W-1:0]   cur_xor;
  logic [mfp_pkg::BYTE_W-1:0]   cur_cmd;

  assign sel       = PIW'(in_port);
  assign port_ok   = (32'(in_port) < PORTS);
  assign cur_phase = phase_r[sel];
  assign cur_size  = size_r[sel];
  assign cur_taken = taken_r[sel];
  assign cur_xor   = xor_r[sel];
  assign cur_cmd   = cmd_r[sel];
  assign has_room  = (cur_taken < cur_size) &&
                     (cur_taken < mfp_pkg::SIZE_W'(MAX_PAYLOAD));
  assign size_ok   = (in_byte <= mfp_pkg::BYTE_W'(MAX_PAYLOAD));

  // a port whose last frame is still being sent holds off, so its payload stays intact
  assign in_ready = !port_ok || (!busy_r[sel] && !q_full);
  assign accept   = in_valid && in_ready && port_ok;

  always_comb begin
    phase_nxt = cur_phase;
    case (cur_phase)
      mfp_pkg::PH_IDLE: begin
        phase_nxt = (in_byte == mfp_pkg::HDR_DOLLAR) ? mfp_pkg::PH_DOLLAR : mfp_pkg::PH_IDLE;
      end
      mfp_pkg::PH_DOLLAR: begin
        phase_nxt = (in_byte == mfp_pkg::HDR_M) ? mfp_pkg::PH_M : mfp_pkg::PH_IDLE;
      end
      mfp_pkg::PH_M: begin
        phase_nxt = (in_byte == mfp_pkg::HDR_ARROW) ? mfp_pkg::PH_ARROW : mfp_pkg::PH_IDLE;
      end
      mfp_pkg::PH_ARROW: begin
        phase_nxt = size_ok ? mfp_pkg::PH_CMD : mfp_pkg::PH_IDLE;
      end
      mfp_pkg::PH_CMD: begin
        phase_nxt = mfp_pkg::PH_DATA;
      end
      mfp_pkg::PH_DATA: begin
        phase_nxt = has_room ? mfp_pkg::PH_DATA : mfp_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = mfp_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    wr.en             = 1'b0;
    wr.port           = in_port;
    wr.idx            = cur_taken[mfp_pkg::INDEX_W-1:0];
    wr.data           = in_byte;
    push              = 1'b0;
    push_desc.port    = in_port;
    push_desc.command = cur_cmd;
    push_desc.size    = cur_size;
    if (accept && (cur_phase == mfp_pkg::PH_DATA)) begin
      if (has_room) begin
        wr.en = 1'b1;
      end else if (cur_xor == in_byte) begin
        push = 1'b1;
      end
    end
  end

  // a port turns busy when its frame is queued and free once its last result is sent
  always_comb begin
    busy_nxt = busy_r;
    if (push) begin
      busy_nxt[sel] = 1'b1;
    end
    if (done.valid) begin
      busy_nxt[PIW'(done.port)] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORTS; i++) begin
        phase_r[i] <= mfp_pkg::PH_IDLE;
        size_r[i]  <= '0;
        taken_r[i] <= '0;
        xor_r[i]   <= '0;
        cmd_r[i]   <= '0;
      end
      busy_r <= '0;
    end else begin
      if (accept) begin
        phase_r[sel] <= phase_nxt;
        case (cur_phase)
          mfp_pkg::PH_ARROW: begin
            if (size_ok) begin
              size_r[sel]  <= in_byte[mfp_pkg::SIZE_W-1:0];
              taken_r[sel] <= '0;
              xor_r[sel]   <= in_byte;
            end
          end
          mfp_pkg::PH_CMD: begin
            cmd_r[sel] <= in_byte;
            xor_r[sel] <= cur_xor ^ in_byte;
          end
          mfp_pkg::PH_DATA: begin
            if (has_room) begin
              xor_r[sel]   <= cur_xor ^ in_byte;
              taken_r[sel] <= cur_taken + 7'd1;
            end
          end
          default: begin
          end
        endcase
      end
      busy_r <= busy_nxt;
    end
  end

endmodule

[rtl/mfp_queue.sv]
// small fifo of checked frames between front and back
`timescale 1ns / 1ps

module mfp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mfp_pkg::frame_desc_t push_desc,
  input  logic                 pop,
  output mfp_pkg::frame_desc_t head,
  output logic                 full,
  output logic                 empty
);

  localparam int AW = (mfp_pkg::Q_DEPTH > 1) ? $clog2(mfp_pkg::Q_DEPTH) : 1;

  mfp_pkg::frame_desc_t entries_r [mfp_pkg::Q_DEPTH];
  logic [AW-1:0]        wr_ptr_r;
  logic [AW-1:0]        rd_ptr_r;
  logic [AW:0]          count_r;

  assign full  = (count_r == (AW+1)'(mfp_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

  // queue depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/mfp_back.sv]
// payload store and result sequencer that sends each checked frame byte by byte
`timescale 1ns / 1ps

module mfp_back #(
  parameter int PORTS       = mfp_pkg::DEF_PORTS,
  parameter int MAX_PAYLOAD = mfp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mfp_pkg::mem_wr_t            wr,
  input  logic                        q_empty,
  input  mfp_pkg::frame_desc_t        q_head,
  output logic                        q_pop,
  output mfp_pkg::frame_done_t        done,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mfp_pkg::PORT_W-1:0]  out_src_port,
  output logic [mfp_pkg::BYTE_W-1:0]  out_command,
  output logic [mfp_pkg::SIZE_W-1:0]  out_payload_size,
  output logic [mfp_pkg::INDEX_W-1:0] out_byte_index,
  output logic [mfp_pkg::BYTE_W-1:0]  out_payload_byte,
  output logic                        out_last
);

  localparam int PIW    = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int IW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int AW     = PIW + IW;
  localparam int MDEPTH = 1 << AW;

  logic [mfp_pkg::BYTE_W-1:0] payload_mem [MDEPTH];
  logic [mfp_pkg::BYTE_W-1:0] rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;

  mfp_pkg::back_state_t       state_r;
  mfp_pkg::back_state_t       state_nxt;
  mfp_pkg::frame_desc_t       desc_r;
  logic [mfp_pkg::SIZE_W-1:0] cnt_r;
  logic                       last_c;
  logic                       empty_frame;

  assign rd_addr     = {PIW'(desc_r.port), IW'(cnt_r)};
  assign wr_addr     = {PIW'(wr.port), IW'(wr.idx)};
  assign empty_frame = (desc_r.size == '0);
  assign last_c      = empty_frame || ((cnt_r + 7'd1) == desc_r.size);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      payload_mem[wr_addr] <= wr.data;
    end
    rd_data_r <= payload_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfp_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = mfp_pkg::B_READ;
        end
      end
      mfp_pkg::B_READ: begin
        state_nxt = mfp_pkg::B_OUT;
      end
      mfp_pkg::B_OUT: begin
        if (out_ready) begin
          state_nxt = last_c ? mfp_pkg::B_IDLE : mfp_pkg::B_READ;
        end
      end
      default: begin
        state_nxt = mfp_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop      = (state_r == mfp_pkg::B_IDLE) && !q_empty;
    out_valid  = (state_r == mfp_pkg::B_OUT);
    done.valid = out_valid && out_ready && last_c;
    done.port  = desc_r.port;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfp_pkg::B_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) begin
        cnt_r <= '0;
      end else if (out_valid && out_ready && !last_c) begin
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
  end

  assign out_src_port     = desc_r.port;
  assign out_command      = desc_r.command;
  assign out_payload_size = desc_r.size;
  assign out_byte_index   = cnt_r[mfp_pkg::INDEX_W-1:0];
  assign out_payload_byte = empty_frame ? '0 : rd_data_r;
  assign out_last         = last_c;

endmodule

[rtl/msp_frame_parser_top.sv]
// top level of the serial-protocol frame parser: front, frame queue and back
`timescale 1ns / 1ps

// Receive-side frame parser with one independent parser per serial port.
// Input stream: one received byte per transfer, tagged with its port. Bytes on
// ports at or above PORTS are taken and ignored.
// Output stream: one transfer per payload byte of each frame whose header, size
// and checksum are good (one transfer for an empty payload), tlast on the final
// one. Bad frames vanish without a trace.
// Throughput: the front takes one byte per cycle. A byte for a port whose
// previous frame has not been sent out completely, or any byte for a port
// below PORTS while the two-entry frame queue is full, waits with tready low.
// Order: a checked frame is queued; the back pops it, reads the payload store
// in B_READ and presents the result in B_OUT. Each further result goes back
// through B_READ once the one before is taken, as the store read is registered.
// Reset (synchronous, active low) puts every port back to hunting for '$',
// empties the queue and drops any frame being sent; the payload store itself
// is not cleared. A stalled receiver holds the back on the current result while
// the front goes on parsing the other ports until the frame queue is full.

module msp_frame_parser_top #(
  parameter int PORTS       = mfp_pkg::DEF_PORTS,
  parameter int MAX_PAYLOAD = mfp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] port, [9:2] rx_byte, [15:10] zero
  input  logic [mfp_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] src_port, [9:2] command, [16:10] payload_size, [22:17] byte_index,
  // [30:23] payload_byte, [31] zero
  output logic [mfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);

  logic                        push;
  mfp_pkg::frame_desc_t        push_desc;
  mfp_pkg::mem_wr_t            wr;
  mfp_pkg::frame_done_t        done;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_pop;
  mfp_pkg::frame_desc_t        q_head;

  logic [mfp_pkg::PORT_W-1:0]  src_port;
  logic [mfp_pkg::BYTE_W-1:0]  command;
  logic [mfp_pkg::SIZE_W-1:0]  payload_size;
  logic [mfp_pkg::INDEX_W-1:0] byte_index;
  logic [mfp_pkg::BYTE_W-1:0]  payload_byte;

  mfp_front #(
    .PORTS       (PORTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_port   (in_tdata[1:0]),
    .in_byte   (in_tdata[9:2]),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr),
    .done      (done)
  );

  mfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  mfp_back #(
    .PORTS       (PORTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr               (wr),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .done             (done),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_src_port     (src_port),
    .out_command      (command),
    .out_payload_size (payload_size),
    .out_byte_index   (byte_index),
    .out_payload_byte (payload_byte),
    .out_last         (out_tlast)
  );

  assign out_tdata = {1'b0, payload_byte, byte_index, payload_size, command, src_port};

  // a frame is queued only when there is room for it
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_full)
    else $error("frame pushed into full queue");

  // the checksum byte never also writes the payload store
  assert property (@(posedge clk) disable iff (!rst_n) !(push && wr.en))
    else $error("payload write and frame push in the same cycle");

  // a port cannot queue a new frame in the cycle its old one finishes sending
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && done.valid) |-> (push_desc.port != done.port))
    else $error("frame push on a port that is still being sent");

  // an empty frame is a single result that closes the frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (payload_size == '0)) |-> (out_tlast && (byte_index == '0)))
    else $error("empty frame result without last or with nonzero index");

endmodule
